FILE: hw/rtl/tfvn_pkg.sv
// shared types and constants of the tileable fbm value noise block
`timescale 1ns / 1ps
package tfvn_pkg;

  // field and register widths
  localparam int CoordW  = 12;
  localparam int SizeW   = 13;
  localparam int SeedW   = 32;
  localparam int OctW    = 4;
  localparam int GainW   = 16;
  localparam int ValW    = 16;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // tile and octave limits
  localparam logic [SizeW-1:0] MaxSize    = 13'd4096;
  localparam logic [OctW-1:0]  MaxOctaves = 4'd12;

  // shared divider widths
  localparam int DivDw = 56;
  localparam int DivVw = 32;
  localparam int DivCw = 6;

  // hash and blend constants
  localparam logic [31:0] HashK1   = 32'h9E3779B9;
  localparam logic [31:0] HashK2   = 32'h85EBCA6B;
  localparam logic [31:0] HashK3   = 32'h2545F491;
  localparam logic [31:0] HashK4   = 32'hC2B2AE35;
  localparam logic [31:0] SeedStep = 32'd7919;
  localparam logic [17:0] SmoothK  = 18'd196608;
  localparam logic [31:0] AmpInit  = 32'd32768;

  // register indexes
  localparam logic [CfgAddrW-1:0] CfgImageSize = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgNoiseSeed = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgPeriodX   = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgPeriodY   = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgOctCount  = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgOctGain   = 3'd5;

  typedef struct packed {
    logic [SizeW-1:0] image_size;
    logic [SeedW-1:0] noise_seed;
    logic [SizeW-1:0] cells_x;
    logic [SizeW-1:0] cells_y;
    logic [OctW-1:0]  octave_count;
    logic [GainW-1:0] octave_gain;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DivDw-1:0] dividend;
    logic [DivVw-1:0] divisor;
    logic [DivCw-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDw-1:0] quotient;
    logic [DivVw-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: hw/rtl/tfvn_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tfvn_div import tfvn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q;
  logic             done_q;
  logic [DivCw-1:0] cnt_q;
  logic [DivDw-1:0] dvd_q;
  logic [DivVw-1:0] dvs_q;
  logic [DivVw-1:0] rem_q;
  logic [DivDw-1:0] quo_q;
  logic [DivVw+1:0] trial;
  logic             fits;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {1'b0, rem_q, dvd_q[DivDw-1]} - {2'b00, dvs_q};
  assign fits  = ~trial[DivVw+1];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCw'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, dividend arrives msb aligned
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DivVw-1:0] : {rem_q[DivVw-2:0], dvd_q[DivDw-1]};
      quo_q <= {quo_q[DivDw-2:0], fits};
      dvd_q <= {dvd_q[DivDw-2:0], 1'b0};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: hw/rtl/tfvn_core.sv
// sequencer with shared multiplier, drives the shared divider
`timescale 1ns / 1ps
module tfvn_core import tfvn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CoordW-1:0] pixel_x_i,
  input  logic [CoordW-1:0] pixel_y_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [ValW-1:0]   noise_value_o,
  output logic              coord_error_o
);

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StNmul = 5'd1;
  localparam logic [4:0] StD1   = 5'd2;
  localparam logic [4:0] StD1w  = 5'd3;
  localparam logic [4:0] StD2   = 5'd4;
  localparam logic [4:0] StD2w  = 5'd5;
  localparam logic [4:0] StD3   = 5'd6;
  localparam logic [4:0] StD3w  = 5'd7;
  localparam logic [4:0] StSm1  = 5'd8;
  localparam logic [4:0] StSm2  = 5'd9;
  localparam logic [4:0] StSm3  = 5'd10;
  localparam logic [4:0] StH1   = 5'd11;
  localparam logic [4:0] StH2   = 5'd12;
  localparam logic [4:0] StH3   = 5'd13;
  localparam logic [4:0] StH4   = 5'd14;
  localparam logic [4:0] StH5   = 5'd15;
  localparam logic [4:0] StB1   = 5'd16;
  localparam logic [4:0] StB2   = 5'd17;
  localparam logic [4:0] StB3   = 5'd18;
  localparam logic [4:0] StB4   = 5'd19;
  localparam logic [4:0] StB5   = 5'd20;
  localparam logic [4:0] StB6   = 5'd21;
  localparam logic [4:0] StB7   = 5'd22;
  localparam logic [4:0] StB8   = 5'd23;
  localparam logic [4:0] StB9   = 5'd24;
  localparam logic [4:0] StA1   = 5'd25;
  localparam logic [4:0] StA2   = 5'd26;
  localparam logic [4:0] StA3   = 5'd27;
  localparam logic [4:0] StF    = 5'd28;
  localparam logic [4:0] StFw   = 5'd29;
  localparam logic [4:0] StDone = 5'd30;

  logic [4:0] state_q, state_d;

  // per item registers
  logic [CoordW-1:0] x_q, y_q;
  logic [SizeW-1:0]  size_q, px_q, py_q;
  logic [OctW-1:0]   octs_q, oct_q;
  logic [31:0]       seed_q, amp_q, total_q;
  logic [55:0]       acc_q;
  logic              ax_q;
  // per axis working registers
  logic [24:0]       ix_q;
  logic [11:0]       r_q;
  logic [15:0]       f_q;
  logic [SizeW-1:0]  x0_q, x1_q, y0_q, y1_q;
  logic [16:0]       sx_q, sy_q;
  // hash and blend registers
  logic [1:0]        k_q;
  logic [31:0]       h_q;
  logic [23:0]       corner_q [4];
  logic [40:0]       t_q, top_q, bot_q;
  logic [57:0]       bl_q;
  logic [63:0]       prod_q;
  logic [ValW-1:0]   val_q;
  logic              err_q;

  // shared multiplier operands and helpers
  logic [31:0]      mul_a, mul_b;
  logic [31:0]      hx, hy, hz;
  logic [SizeW-1:0] coord_sel, per_sel, cx, cy, c0, c1;
  logic [16:0]      wx, wy;
  logic [SizeW:0]   px2, py2;
  logic             last_oct, bad;
  logic [SizeW-1:0] size_eff, px_eff, py_eff;
  logic [OctW-1:0]  octs_eff;
  div_req_t         dreq;
  div_rsp_t         drsp;

  tfvn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // effective configuration for a new item
  always_comb begin
    size_eff = (cfg_i.image_size == '0) ? SizeW'(1) : cfg_i.image_size;
    if (size_eff > MaxSize) size_eff = MaxSize;
    px_eff   = (cfg_i.cells_x == '0) ? SizeW'(1) : cfg_i.cells_x;
    py_eff   = (cfg_i.cells_y == '0) ? SizeW'(1) : cfg_i.cells_y;
    octs_eff = (cfg_i.octave_count == '0) ? OctW'(1) : cfg_i.octave_count;
    if (octs_eff > MaxOctaves) octs_eff = MaxOctaves;
    bad = ({1'b0, pixel_x_i} >= size_eff) || ({1'b0, pixel_y_i} >= size_eff);
  end

  // shared operand selection and small helpers
  always_comb begin
    coord_sel = ax_q ? {1'b0, y_q} : {1'b0, x_q};
    per_sel   = ax_q ? py_q : px_q;
    cx        = k_q[0] ? x1_q : x0_q;
    cy        = k_q[1] ? y1_q : y0_q;
    c0        = drsp.remainder[SizeW-1:0];
    c1        = ((c0 + 1'b1) == per_sel) ? '0 : c0 + 1'b1;
    wx        = 17'h10000 - sx_q;
    wy        = 17'h10000 - sy_q;
    hx        = h_q ^ prod_q[31:0];
    hx        = hx ^ (hx >> 15);
    hy        = prod_q[31:0] ^ (prod_q[31:0] >> 13);
    hz        = prod_q[31:0] ^ (prod_q[31:0] >> 16);
    px2       = {px_q, 1'b0};
    py2       = {py_q, 1'b0};
    last_oct  = (oct_q == octs_q - 1'b1) || (px2 > {1'b0, size_q})
                || (py2 > {1'b0, size_q});
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StNmul: begin mul_a = 32'(coord_sel); mul_b = 32'(per_sel); end
      StSm1:  begin mul_a = 32'(f_q); mul_b = 32'(f_q); end
      StSm2:  begin mul_a = prod_q[31:0]; mul_b = 32'(SmoothK - {1'b0, f_q, 1'b0}); end
      StH1:   begin mul_a = 32'(cx); mul_b = HashK1; end
      StH2:   begin mul_a = 32'(cy); mul_b = HashK2; end
      StH3:   begin mul_a = hx; mul_b = HashK3; end
      StH4:   begin mul_a = hy; mul_b = HashK4; end
      StB1:   begin mul_a = 32'(corner_q[0]); mul_b = 32'(wx); end
      StB2:   begin mul_a = 32'(corner_q[1]); mul_b = 32'(sx_q); end
      StB3:   begin mul_a = 32'(corner_q[2]); mul_b = 32'(wx); end
      StB4:   begin mul_a = 32'(corner_q[3]); mul_b = 32'(sx_q); end
      StB5:   begin mul_a = 32'(top_q[23:0]); mul_b = 32'(wy); end
      StB6:   begin mul_a = 32'(top_q[40:24]); mul_b = 32'(wy); end
      StB7:   begin mul_a = 32'(bot_q[23:0]); mul_b = 32'(sy_q); end
      StB8:   begin mul_a = 32'(bot_q[40:24]); mul_b = 32'(sy_q); end
      StA1:   begin mul_a = 32'(bl_q[55:32]); mul_b = amp_q; end
      StA2:   begin mul_a = amp_q; mul_b = 32'(cfg_i.octave_gain); end
      default: ;
    endcase
  end

  // divider requests, dividends aligned to the top bit
  always_comb begin
    dreq = '0;
    unique case (state_q)
      StD1: begin
        dreq.start    = 1'b1;
        dreq.dividend = {prod_q[24:0], 31'b0};
        dreq.divisor  = 32'(size_q);
        dreq.nbits    = DivCw'(25);
      end
      StD2: begin
        dreq.start    = 1'b1;
        dreq.dividend = {r_q, 16'b0, 28'b0};
        dreq.divisor  = 32'(size_q);
        dreq.nbits    = DivCw'(28);
      end
      StD3: begin
        dreq.start    = 1'b1;
        dreq.dividend = {ix_q, 31'b0};
        dreq.divisor  = 32'(per_sel);
        dreq.nbits    = DivCw'(25);
      end
      StF: begin
        dreq.start    = 1'b1;
        dreq.dividend = acc_q;
        dreq.divisor  = total_q;
        dreq.nbits    = DivCw'(56);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = bad ? StDone : StNmul;
      StNmul: state_d = StD1;
      StD1:   state_d = StD1w;
      StD1w:  if (drsp.done) state_d = StD2;
      StD2:   state_d = StD2w;
      StD2w:  if (drsp.done) state_d = StD3;
      StD3:   state_d = StD3w;
      StD3w:  if (drsp.done) state_d = StSm1;
      StSm1:  state_d = StSm2;
      StSm2:  state_d = StSm3;
      StSm3:  state_d = ax_q ? StH1 : StNmul;
      StH1:   state_d = StH2;
      StH2:   state_d = StH3;
      StH3:   state_d = StH4;
      StH4:   state_d = StH5;
      StH5:   state_d = (k_q == 2'd3) ? StB1 : StH1;
      StB1:   state_d = StB2;
      StB2:   state_d = StB3;
      StB3:   state_d = StB4;
      StB4:   state_d = StB5;
      StB5:   state_d = StB6;
      StB6:   state_d = StB7;
      StB7:   state_d = StB8;
      StB8:   state_d = StB9;
      StB9:   state_d = StA1;
      StA1:   state_d = StA2;
      StA2:   state_d = StA3;
      StA3:   state_d = last_oct ? StF : StNmul;
      StF:    state_d = StFw;
      StFw:   if (drsp.done) state_d = StDone;
      StDone: if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      StIdle: begin
        x_q     <= pixel_x_i;
        y_q     <= pixel_y_i;
        size_q  <= size_eff;
        px_q    <= px_eff;
        py_q    <= py_eff;
        octs_q  <= octs_eff;
        oct_q   <= '0;
        seed_q  <= cfg_i.noise_seed;
        amp_q   <= AmpInit;
        acc_q   <= '0;
        total_q <= '0;
        ax_q    <= 1'b0;
        k_q     <= '0;
        val_q   <= '0;
        err_q   <= bad;
      end
      StD1w: if (drsp.done) begin
        ix_q <= drsp.quotient[24:0];
        r_q  <= drsp.remainder[11:0];
      end
      StD2w: if (drsp.done) f_q <= drsp.quotient[15:0];
      StD3w: if (drsp.done) begin
        if (ax_q) begin
          y0_q <= c0;
          y1_q <= c1;
        end else begin
          x0_q <= c0;
          x1_q <= c1;
        end
      end
      StSm3: begin
        if (ax_q) sy_q <= prod_q[48:32];
        else      sx_q <= prod_q[48:32];
        ax_q <= ~ax_q;
      end
      StH2: h_q <= seed_q ^ prod_q[31:0];
      StH5: begin
        corner_q[k_q] <= hz[23:0];
        k_q <= k_q + 1'b1;
      end
      StB2: t_q   <= prod_q[40:0];
      StB3: top_q <= t_q + prod_q[40:0];
      StB4: t_q   <= prod_q[40:0];
      StB5: bot_q <= t_q + prod_q[40:0];
      StB6: bl_q  <= prod_q[57:0];
      StB7: bl_q  <= bl_q + {prod_q[33:0], 24'b0};
      StB8: bl_q  <= bl_q + prod_q[57:0];
      StB9: bl_q  <= bl_q + {prod_q[33:0], 24'b0};
      StA2: begin
        acc_q   <= acc_q + prod_q[55:0];
        total_q <= total_q + amp_q;
      end
      StA3: begin
        amp_q  <= prod_q[46:15];
        px_q   <= px2[SizeW-1:0];
        py_q   <= py2[SizeW-1:0];
        oct_q  <= oct_q + 1'b1;
        seed_q <= seed_q + SeedStep;
      end
      StFw: if (drsp.done) val_q <= drsp.quotient[23:8];
      default: ;
    endcase
  end

  assign in_ready_o    = (state_q == StIdle);
  assign res_valid_o   = (state_q == StDone);
  assign noise_value_o = val_q;
  assign coord_error_o = err_q;

endmodule

FILE: hw/rtl/tileable_fbm_value_noise.sv
// top level: configuration registers, input stream, output register
//
//  channel  | direction | fields
//  s_axis   | in        | tdata[11:0] pixel_x, tdata[23:12] pixel_y
//  m_axis   | out       | tdata[15:0] noise_value, tuser[0] coord_error
//  cfg      | in        | cfg_we_i, cfg_addr_i (register index), cfg_wdata_i
//
// an item runs through the accept state, one pass per octave (1 to 12 octaves),
// the final normalize and the result state; the single shared bit-serial
// divider sets how long this takes
// an out-of-tile coordinate goes from the accept state straight to the result
// reset restores the register defaults and empties the output register
// s_axis_tready is low while an item is in work; the output register frees
// the core while a finished transaction waits on m_axis_tready
`timescale 1ns / 1ps
module tileable_fbm_value_noise import tfvn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // pixel_x, pixel_y
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // noise_value
  output logic [0:0]          m_axis_tuser,  // coord_error
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t            cfg_q;
  logic            res_valid, res_ready;
  logic [ValW-1:0] res_value;
  logic            res_err;
  logic            m_valid_q;
  logic [ValW-1:0] m_value_q;
  logic            m_err_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_size   <= 13'd256;
      cfg_q.noise_seed   <= '0;
      cfg_q.cells_x      <= 13'd8;
      cfg_q.cells_y      <= 13'd8;
      cfg_q.octave_count <= 4'd4;
      cfg_q.octave_gain  <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgImageSize: cfg_q.image_size   <= cfg_wdata_i[SizeW-1:0];
        CfgNoiseSeed: cfg_q.noise_seed   <= cfg_wdata_i[SeedW-1:0];
        CfgPeriodX:   cfg_q.cells_x      <= cfg_wdata_i[SizeW-1:0];
        CfgPeriodY:   cfg_q.cells_y      <= cfg_wdata_i[SizeW-1:0];
        CfgOctCount:  cfg_q.octave_count <= cfg_wdata_i[OctW-1:0];
        CfgOctGain:   cfg_q.octave_gain  <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  tfvn_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .pixel_x_i     (s_axis_tdata[11:0]),
    .pixel_y_i     (s_axis_tdata[23:12]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .noise_value_o (res_value),
    .coord_error_o (res_err)
  );

  // output register
  assign res_ready = ~m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_value_q <= res_value;
      m_err_q   <= res_err;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_value_q;
  assign m_axis_tuser  = m_err_q;

endmodule

FILE: dv/tileable_fbm_value_noise_tb.sv
// testbench of the tileable fbm value noise block: stream driver, predictor and checker
`timescale 1ns / 1ps
module tileable_fbm_value_noise_tb;
  import tfvn_pkg::*;

  localparam longint unsigned CycleLimit = 64'd40_000_000;

  typedef struct packed {
    logic [ValW-1:0] noise_value;
    logic            coord_error;
  } texel_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // register copies kept by the predictor
  logic [SizeW-1:0] size_r = 13'd256;
  logic [SeedW-1:0] seed_r = '0;
  logic [SizeW-1:0] perx_r = 13'd8;
  logic [SizeW-1:0] pery_r = 13'd8;
  logic [OctW-1:0]  oct_r  = 4'd4;
  logic [GainW-1:0] gain_r = 16'd16384;

  logic [23:0]      texel_q[$];
  texel_res_t       height_q[$];
  logic             in_fire = 1'b0;
  bit               calm = 1'b0;
  int unsigned      errs = 0;
  longint unsigned  cycles = 0;

  tileable_fbm_value_noise dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] corner_hash(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] seed);
    logic [31:0] h;
    h = seed ^ (cx * HashK1) ^ (cy * HashK2);
    h = h ^ (h >> 15);
    h = h * HashK3;
    h = h ^ (h >> 13);
    h = h * HashK4;
    h = h ^ (h >> 16);
    return {8'd0, h[23:0]};
  endfunction

  function automatic longint unsigned smooth16(longint unsigned f);
    return (f * f * (64'd196608 - 2 * f)) >> 32;
  endfunction

  // one octave of wrapped value noise, q0.24
  function automatic longint unsigned octave_height(longint unsigned x, longint unsigned y,
      longint unsigned sz, longint unsigned px, longint unsigned py, logic [31:0] seed);
    longint unsigned nx, ny, ix, iy, sx, sy, a, b, c, d, top, bot;
    nx = x * px;
    ny = y * py;
    ix = nx / sz;
    iy = ny / sz;
    sx = smooth16(((nx % sz) << 16) / sz);
    sy = smooth16(((ny % sz) << 16) / sz);
    a = 64'(corner_hash(32'(ix % px), 32'(iy % py), seed));
    b = 64'(corner_hash(32'((ix + 1) % px), 32'(iy % py), seed));
    c = 64'(corner_hash(32'(ix % px), 32'((iy + 1) % py), seed));
    d = 64'(corner_hash(32'((ix + 1) % px), 32'((iy + 1) % py), seed));
    top = a * (65536 - sx) + b * sx;
    bot = c * (65536 - sx) + d * sx;
    return (top * (65536 - sy) + bot * sy) >> 32;
  endfunction

  function automatic texel_res_t fbm_height(logic [23:0] coord);
    longint unsigned x, y, sz, px, py, acc, total, amp;
    int unsigned octs;
    texel_res_t r;
    x = 64'(coord[11:0]);
    y = 64'(coord[23:12]);
    sz = (size_r == 0) ? 64'd1 : 64'(size_r);
    if (sz > 4096) sz = 4096;
    px = (perx_r == 0) ? 64'd1 : 64'(perx_r);
    py = (pery_r == 0) ? 64'd1 : 64'(pery_r);
    octs = (oct_r == 0) ? 32'd1 : 32'(oct_r);
    if (octs > 32'(MaxOctaves)) octs = 32'(MaxOctaves);
    acc = 0;
    total = 0;
    amp = 32768;
    r = '0;
    if (x >= sz || y >= sz) begin
      r.coord_error = 1'b1;
      return r;
    end
    for (int o = 0; o < octs; o++) begin
      acc += octave_height(x, y, sz, px, py, seed_r + 32'(o) * SeedStep) * amp;
      total += amp;
      amp = (amp * 64'(gain_r)) >> 15;
      if (px * 2 > sz || py * 2 > sz) break;
      px *= 2;
      py *= 2;
    end
    r.noise_value = ValW'((total != 0) ? ((acc / total) >> 8) : 64'd0);
    return r;
  endfunction

  // accept, predict and check at the rising edge
  always @(posedge clk_i) begin
    texel_res_t want;
    cycles <= cycles + 1;
    in_fire <= s_axis_tvalid & s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) height_q.push_back(fbm_height(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      if (height_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errs++;
      end else begin
        want = height_q.pop_front();
        if (m_axis_tdata !== want.noise_value) begin
          $error("noise_value expected %0d actual %0d", want.noise_value, m_axis_tdata);
          errs++;
        end
        if (m_axis_tuser[0] !== want.coord_error) begin
          $error("coord_error expected %0d actual %0d", want.coord_error, m_axis_tuser[0]);
          errs++;
        end
      end
    end
  end

  // input driver and output backpressure at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (texel_q.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= texel_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("tileable_fbm_value_noise verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (texel_q.size() != 0 || s_axis_tvalid || height_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgImageSize: size_r = val[SizeW-1:0];
      CfgNoiseSeed: seed_r = val;
      CfgPeriodX:   perx_r = val[SizeW-1:0];
      CfgPeriodY:   pery_r = val[SizeW-1:0];
      CfgOctCount:  oct_r = val[OctW-1:0];
      CfgOctGain:   gain_r = val[GainW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // directed corners inside and just outside the tile, then random texels mostly inside it
  task automatic queue_texels(int n);
    int unsigned sz, x, y;
    sz = (size_r == 0) ? 1 : ((size_r > 4096) ? 4096 : size_r);
    texel_q.push_back(24'd0);
    texel_q.push_back({12'(sz - 1), 12'(sz - 1)});
    texel_q.push_back({12'd0, 12'(sz)});
    texel_q.push_back({12'(sz), 12'd0});
    texel_q.push_back(24'hFFFFFF);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) begin
        x = $urandom_range(sz - 1, 0);
        y = $urandom_range(sz - 1, 0);
      end else begin
        x = $urandom_range(4095, 0);
        y = $urandom_range(4095, 0);
      end
      texel_q.push_back({12'(y), 12'(x)});
    end
  endtask

  task automatic run_phase(logic [31:0] sz, logic [31:0] seed, logic [31:0] px,
                           logic [31:0] py, logic [31:0] octs, logic [31:0] gain, int n);
    wait_drained();
    write_reg(CfgImageSize, sz);
    write_reg(CfgNoiseSeed, seed);
    write_reg(CfgPeriodX, px);
    write_reg(CfgPeriodY, py);
    write_reg(CfgOctCount, octs);
    write_reg(CfgOctGain, gain);
    queue_texels(n);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // reset defaults first
    queue_texels(150);
    // zero size, zero periods, zero octave count, zero gain
    run_phase(0, $urandom, 0, 0, 0, 0, 30);
    // oversize tile, widest periods, octave count over the limit, largest gain
    run_phase(13'h1FFF, 32'hFFFFFFFF, 4096, 4096, 15, 65535, 40);
    // full tile with the most octaves
    run_phase(4096, $urandom, 1, 3, 12, 65535, 25);
    // long stretch without idling
    wait_drained();
    calm = 1'b1;
    run_phase(64, $urandom, 5, 2, 3, 32768, 250);
    wait_drained();
    calm = 1'b0;
    run_phase(300, $urandom, 7, 7, 6, 20000, 250);
    run_phase(1000, $urandom, 16, 9, 2, 1, 250);
    run_phase(4096, $urandom, 4096, 2048, 12, $urandom_range(65535), 100);
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (errs == 0 && height_q.size() == 0) begin
      $display("tileable_fbm_value_noise verification clean");
    end else begin
      $display("tileable_fbm_value_noise verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tfvn_pkg.sv
hw/rtl/tfvn_div.sv
hw/rtl/tfvn_core.sv
hw/rtl/tileable_fbm_value_noise.sv
dv/tileable_fbm_value_noise_tb.sv
